// ===== src/ugs_pkg.sv =====
// ----------------------------------------------------------------------------
// ugs_pkg
// shared types and constants of the undirected graph store
// ----------------------------------------------------------------------------
package ugs_pkg;

    // table size and id width
    localparam int MAX_VERTICES = 8;
    localparam int ID_BITS      = 16;
    localparam int SLOT_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    // command codes
    localparam logic [2:0] MODE_ADD_VERTEX = 3'd0;
    localparam logic [2:0] MODE_ADD_EDGE   = 3'd1;
    localparam logic [2:0] MODE_DEL_EDGE   = 3'd2;
    localparam logic [2:0] MODE_DEL_VERTEX = 3'd3;
    localparam logic [2:0] MODE_FIND_VERTEX = 3'd4;
    localparam logic [2:0] MODE_FIND_EDGE  = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EXISTS  = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef logic [SLOT_W-1:0]       t_slot;
    typedef logic [ID_BITS-1:0]      t_id;
    typedef logic [MAX_VERTICES-1:0] t_row;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] vertex_a;
        logic [15:0] vertex_b;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
    } t_rsp;

endpackage

// ===== src/undirected_graph_store.sv =====
// a request accepted while idle is scanned one slot per cycle, then loads its result into the
// output register from the execute state, later only while an earlier result is still stalled there
// no new request is taken during the scan and execute states, only once the sequencer is idle
// the result sits in an output register, so a new request is taken while it waits
// reset (synchronous, active low) empties the slot table and clears every adjacency row
// slot ids are not cleared; they are read only for used slots
// ----------------------------------------------------------------------------
// undirected_graph_store
// undirected graph of up to MAX_VERTICES vertices held as a slot table plus a
// symmetric adjacency bit matrix; one shared slot read feeds two id comparators that scan the slots
// ----------------------------------------------------------------------------
module undirected_graph_store (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // request channel
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  ugs_pkg::t_req i_req,
    // response channel
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output ugs_pkg::t_rsp o_rsp
);

    // sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state r_state, n_state;

    // slot table and adjacency matrix
    logic [ugs_pkg::MAX_VERTICES-1:0] r_used, n_used;
    ugs_pkg::t_id  r_id  [ugs_pkg::MAX_VERTICES];
    ugs_pkg::t_row r_row [ugs_pkg::MAX_VERTICES];
    ugs_pkg::t_row n_row [ugs_pkg::MAX_VERTICES];

    // captured request and scan results
    ugs_pkg::t_req  r_req;
    ugs_pkg::t_slot r_idx;
    ugs_pkg::t_slot r_sa, r_sb, r_free;
    logic           r_sa_hit, r_sb_hit, r_free_hit;

    // output register
    logic          r_out_valid;
    ugs_pkg::t_rsp r_out, n_out;

    ugs_pkg::t_id w_ida, w_idb;
    logic         w_accept;
    logic         w_commit;
    logic         w_hit_a, w_hit_b;
    logic         w_edge;
    logic         w_id_we;
    logic         w_last;

    assign w_ida = r_req.vertex_a[ugs_pkg::ID_BITS-1:0];
    assign w_idb = r_req.vertex_b[ugs_pkg::ID_BITS-1:0];

    // new request only while the sequencer is idle
    assign o_req_stall = (r_state != S_IDLE);
    assign w_accept    = i_req_valid && !o_req_stall;

    // the shared slot read: current slot compared against both ids
    assign w_hit_a = r_used[r_idx] && (r_id[r_idx] == w_ida);
    assign w_hit_b = r_used[r_idx] && (r_id[r_idx] == w_idb);
    assign w_last  = (r_idx == ugs_pkg::SLOT_W'(ugs_pkg::MAX_VERTICES - 1));

    // commit once the output register is free or being drained
    assign w_commit = (r_state == S_EXEC) && (!r_out_valid || !i_rsp_stall);

    // edge present between the two endpoints (false unless both hit)
    assign w_edge = r_sa_hit && r_sb_hit && r_row[r_sa][r_sb];

    // ------------------------------------------------------------------
    // command execution: state update and response
    // ------------------------------------------------------------------
    always_comb begin
        n_used       = r_used;
        n_row        = r_row;
        w_id_we      = 1'b0;
        n_out.status = ugs_pkg::ST_MISSING;
        n_out.found  = 1'b0;
        unique case (r_req.mode)
            ugs_pkg::MODE_ADD_VERTEX: begin
                if (r_sa_hit) begin
                    n_out.status = ugs_pkg::ST_EXISTS;
                    n_out.found  = 1'b1;
                end else if (r_free_hit) begin
                    // take the lowest free slot with a clean row and column
                    n_used[r_free] = 1'b1;
                    w_id_we        = 1'b1;
                    n_row[r_free]  = '0;
                    for (int i = 0; i < ugs_pkg::MAX_VERTICES; i++) begin
                        n_row[i][r_free] = 1'b0;
                    end
                    n_out.status = ugs_pkg::ST_OK;
                end else begin
                    n_out.status = ugs_pkg::ST_FULL;
                end
            end
            ugs_pkg::MODE_ADD_EDGE: begin
                if (r_sa_hit && r_sb_hit) begin
                    if (w_edge) begin
                        n_out.status = ugs_pkg::ST_EXISTS;
                        n_out.found  = 1'b1;
                    end else begin
                        n_row[r_sa][r_sb] = 1'b1;
                        n_row[r_sb][r_sa] = 1'b1;
                        n_out.status      = ugs_pkg::ST_OK;
                    end
                end
            end
            ugs_pkg::MODE_DEL_EDGE: begin
                if (w_edge) begin
                    n_row[r_sa][r_sb] = 1'b0;
                    n_row[r_sb][r_sa] = 1'b0;
                    n_out.status      = ugs_pkg::ST_OK;
                    n_out.found       = 1'b1;
                end
            end
            ugs_pkg::MODE_DEL_VERTEX: begin
                if (r_sa_hit) begin
                    // drop every edge touching the vertex, then free the slot
                    n_row[r_sa] = '0;
                    for (int i = 0; i < ugs_pkg::MAX_VERTICES; i++) begin
                        n_row[i][r_sa] = 1'b0;
                    end
                    n_used[r_sa] = 1'b0;
                    n_out.status = ugs_pkg::ST_OK;
                    n_out.found  = 1'b1;
                end
            end
            ugs_pkg::MODE_FIND_VERTEX: begin
                if (r_sa_hit) begin
                    n_out.status = ugs_pkg::ST_OK;
                    n_out.found  = 1'b1;
                end
            end
            ugs_pkg::MODE_FIND_EDGE: begin
                if (w_edge) begin
                    n_out.status = ugs_pkg::ST_OK;
                    n_out.found  = 1'b1;
                end
            end
            default: begin
                // undefined modes change nothing and report missing
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_SCAN;
            S_SCAN: if (w_last)   n_state = S_EXEC;
            S_EXEC: if (w_commit) n_state = S_IDLE;
            default:              n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request capture and slot scan
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req      <= i_req;
            r_idx      <= '0;
            r_sa_hit   <= 1'b0;
            r_sb_hit   <= 1'b0;
            r_free_hit <= 1'b0;
        end else if (r_state == S_SCAN) begin
            r_idx <= r_idx + 1'b1;
            if (w_hit_a && !r_sa_hit) begin
                r_sa     <= r_idx;
                r_sa_hit <= 1'b1;
            end
            if (w_hit_b && !r_sb_hit) begin
                r_sb     <= r_idx;
                r_sb_hit <= 1'b1;
            end
            // first free slot seen is the lowest one
            if (!r_used[r_idx] && !r_free_hit) begin
                r_free     <= r_idx;
                r_free_hit <= 1'b1;
            end
        end
    end

    // slot table and matrix update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            for (int i = 0; i < ugs_pkg::MAX_VERTICES; i++) begin
                r_row[i] <= '0;
            end
        end else if (w_commit) begin
            r_used <= n_used;
            for (int i = 0; i < ugs_pkg::MAX_VERTICES; i++) begin
                r_row[i] <= n_row[i];
            end
        end
    end

    // ids need no reset: only read for used slots
    always_ff @(posedge i_clk) begin
        if (w_commit && w_id_we) begin
            r_id[r_free] <= w_ida;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

`ifndef SYNTHESIS
    // an accepted request starts the scan at slot zero
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN) && (r_idx == '0))
        else $error("scan did not start at slot zero");

    // a free slot never keeps edges
    a_free_row_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !r_used[r_idx]) |-> (r_row[r_idx] == '0))
        else $error("free slot holds edges");

    // a new response only comes from the execute step
    a_rsp_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !$past(o_rsp_valid)) |-> $past(r_state == S_EXEC))
        else $error("response raised outside execute");

    // a full table is never reported together with found
    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status == ugs_pkg::ST_FULL) |-> !o_rsp.found)
        else $error("table full reported with found");
`endif

endmodule
